>>> rtl/core/framed_ascii_position_parser_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the framed ASCII position parser
// ---------------------------------------------------------------------------
`ifndef FRAMED_ASCII_POSITION_PARSER_DEFINES_SVH
`define FRAMED_ASCII_POSITION_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FPP_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fpp assertion failed");

// next-cycle implication, disabled while in reset
`define FPP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fpp assertion failed");

`endif

>>> rtl/core/fpp_pkg.sv
// ---------------------------------------------------------------------------
// fpp_pkg
// Constants shared by the framed ASCII position parser and its checker.
// ---------------------------------------------------------------------------
package fpp_pkg;

  // default frame buffer depth
  localparam int unsigned BufDepthDef = 20;

  // framing characters
  localparam logic [7:0] StartMark = 8'h3C;  // '<'
  localparam logic [7:0] EndMark   = 8'h3E;  // '>'
  localparam logic [7:0] AsciiZero = 8'h30;  // '0'

  // fixed field positions in the frame buffer
  localparam int unsigned PosXHi  = 0;
  localparam int unsigned PosXLo  = 1;
  localparam int unsigned PosYHi  = 3;
  localparam int unsigned PosYLo  = 4;
  localparam int unsigned PosHd2  = 6;
  localparam int unsigned PosHd1  = 7;
  localparam int unsigned PosHd0  = 8;
  localparam int unsigned PosWall = 10;

endpackage

>>> rtl/core/fpp_if.sv
// ---------------------------------------------------------------------------
// fpp_rx_if / fpp_res_if
// Valid/ready channels: received bytes in, decoded position words out.
// ---------------------------------------------------------------------------
interface fpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] heading;
  logic [7:0]  wall_code;
  logic        changed;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output wall_code, output changed, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading,
                  input wall_code, input changed, output ready);
endinterface

>>> rtl/core/framed_ascii_position_parser.sv
// ---------------------------------------------------------------------------
// framed_ascii_position_parser
// Captures frames shaped like <xx,yy,ttt,w> and emits decoded position words.
// ---------------------------------------------------------------------------
// Usage:
//   rx_i  : one received byte per word. '<' clears the write index and arms
//           capture; other bytes are stored while armed; '>' disarms.
//   res_o : one word per '>' that ends an armed frame: x, y, heading, the
//           raw wall byte and a flag telling whether any field differs from
//           the last emitted word.
// Latency: the result word is valid the cycle after the '>' is accepted.
// Throughput: one byte per cycle unless stalled; each byte takes a single pass
//   from the byte port and the buffer flops into the result register.
// Stall: the result register holds its word while res_o.ready is low;
//   rx_i.ready is low only while a word is held and not being taken, so a
//   word taken in the same cycle frees the slot for the next byte.
// Reset: buffer, write index, capture flag, last-emitted fields and the
//   result valid all clear at once; no clearing pass is needed.
// Digit fields are decoded without range checks and wrap modulo the field
// width. Positions not written in a frame keep their old contents.
// ---------------------------------------------------------------------------
module framed_ascii_position_parser #(
  parameter int unsigned BUF_DEPTH = fpp_pkg::BufDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fpp_rx_if.sink   rx_i,
  fpp_res_if.source res_o
);
  import fpp_pkg::*;

  localparam int unsigned IdxW = $clog2(BUF_DEPTH);

  logic [7:0]      buf_q [BUF_DEPTH];
  logic [IdxW-1:0] idx_q, idx_d;
  logic            capt_q, capt_d;
  logic [7:0]      last_x_q, last_y_q, last_wall_q;
  logic [15:0]     last_hd_q;
  logic            out_valid_q;
  logic [7:0]      out_x_q, out_y_q, out_wall_q;
  logic [15:0]     out_hd_q;
  logic            out_chg_q;

  logic            in_acc, is_start, is_end, do_store, do_emit;
  logic [7:0]      dx1, dx0, dy1, dy0;
  logic [15:0]     dh2, dh1, dh0;
  logic [7:0]      x_calc, y_calc, w_calc;
  logic [15:0]     h_calc;
  logic            chg_calc;

  // handshake: slot free when empty or being drained
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign in_acc     = rx_i.valid && rx_i.ready;
  assign is_start   = (rx_i.rx_byte == StartMark);
  assign is_end     = (rx_i.rx_byte == EndMark);
  assign do_store   = in_acc && capt_q && !is_start && !is_end;
  assign do_emit    = in_acc && capt_q && is_end;

  // capture control
  always_comb begin
    idx_d  = idx_q;
    capt_d = capt_q;
    if (in_acc) begin
      if (is_start || is_end) begin
        idx_d  = '0;
        capt_d = is_start;
      end else if (capt_q) begin
        idx_d = (idx_q == IdxW'(BUF_DEPTH - 1)) ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      capt_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      capt_q <= capt_d;
    end
  end

  // frame buffer flops, one write port, fixed read taps
  for (genvar gi = 0; gi < BUF_DEPTH; gi++) begin : g_buf
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        buf_q[gi] <= '0;
      end else if (do_store && idx_q == IdxW'(gi)) begin
        buf_q[gi] <= rx_i.rx_byte;
      end
    end
  end

  // digit decode, wrapping at field width
  assign dx1 = buf_q[PosXHi] - AsciiZero;
  assign dx0 = buf_q[PosXLo] - AsciiZero;
  assign dy1 = buf_q[PosYHi] - AsciiZero;
  assign dy0 = buf_q[PosYLo] - AsciiZero;
  assign dh2 = {8'h00, buf_q[PosHd2]} - {8'h00, AsciiZero};
  assign dh1 = {8'h00, buf_q[PosHd1]} - {8'h00, AsciiZero};
  assign dh0 = {8'h00, buf_q[PosHd0]} - {8'h00, AsciiZero};

  assign x_calc = dx1 * 8'd10 + dx0;
  assign y_calc = dy1 * 8'd10 + dy0;
  assign h_calc = dh2 * 16'd100 + dh1 * 16'd10 + dh0;
  assign w_calc = buf_q[PosWall];

  assign chg_calc = (x_calc != last_x_q) || (y_calc != last_y_q) ||
                    (h_calc != last_hd_q) || (w_calc != last_wall_q);

  // last emitted set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_hd_q   <= '0;
      last_wall_q <= '0;
    end else if (do_emit) begin
      last_x_q    <= x_calc;
      last_y_q    <= y_calc;
      last_hd_q   <= h_calc;
      last_wall_q <= w_calc;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_x_q    <= x_calc;
      out_y_q    <= y_calc;
      out_hd_q   <= h_calc;
      out_wall_q <= w_calc;
      out_chg_q  <= chg_calc;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.pos_x     = out_x_q;
  assign res_o.pos_y     = out_y_q;
  assign res_o.heading   = out_hd_q;
  assign res_o.wall_code = out_wall_q;
  assign res_o.changed   = out_chg_q;

endmodule

>>> rtl/core/fpp_checker.sv
// ---------------------------------------------------------------------------
// fpp_checker
// Port-level assertions for the framed ASCII position parser.
// ---------------------------------------------------------------------------
`include "framed_ascii_position_parser_defines.svh"

module fpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  pos_x_i,
  input logic [7:0]  pos_y_i,
  input logic [15:0] heading_i,
  input logic [7:0]  wall_code_i,
  input logic        changed_i
);
  import fpp_pkg::*;

  logic in_acc;
  logic stall;
  assign in_acc = in_valid_i && in_ready_i;
  assign stall  = out_valid_i && !out_ready_i;

  // stalled result word holds
  `FPP_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall,
    out_valid_i && $stable(pos_x_i) && $stable(pos_y_i) && $stable(heading_i)
    && $stable(wall_code_i) && $stable(changed_i))

  // a new word only follows an accepted end mark
  `FPP_ASSERT_SAME(a_src, clk_i, rst_ni, $rose(out_valid_i),
    $past(in_acc) && ($past(rx_byte_i) == EndMark))

  // bytes other than the end mark never create a word
  `FPP_ASSERT_NEXT(a_noword, clk_i, rst_ni,
    !out_valid_i && (!in_acc || rx_byte_i != EndMark), !out_valid_i)

  // input is only refused while a word is stalled
  `FPP_ASSERT_SAME(a_ready, clk_i, rst_ni, !in_ready_i, stall)

endmodule

bind framed_ascii_position_parser fpp_checker u_fpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rx_i.valid),
  .in_ready_i  (rx_i.ready),
  .rx_byte_i   (rx_i.rx_byte),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .pos_x_i     (res_o.pos_x),
  .pos_y_i     (res_o.pos_y),
  .heading_i   (res_o.heading),
  .wall_code_i (res_o.wall_code),
  .changed_i   (res_o.changed)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives framed position text into the parser, byte by byte, and checks
// every decoded word against typed words or a local frame buffer model:
// a directed table first, then random frames (well formed, short, long,
// restarted, noisy) under varying idle and stall patterns on both channels.
// ---------------------------------------------------------------------------
module testbench;
  import fpp_pkg::*;

  localparam int unsigned BufDepth   = BufDepthDef;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 400;
  localparam logic [7:0]  Comma      = 8'h2C;

  typedef struct packed {
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] heading;
    logic [7:0]  wall_code;
    logic        changed;
  } position_word_t;

  typedef struct packed {
    logic [7:0]     rx_byte;
    logic           typed;
    position_word_t word;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  fpp_rx_if  rx_ch();
  fpp_res_if res_ch();

  framed_ascii_position_parser DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .res_o (res_ch)
  );

  // local copy of the parser state
  logic [7:0]     frame_buf [BufDepth];
  int unsigned    wr_idx;
  bit             armed;
  position_word_t last_word;

  position_word_t pending_words [$];
  stim_row_t      directed_rows [$];
  logic [7:0]     burst [$];
  logic [7:0]     prev_body [11];
  int unsigned    mismatches = 0;
  int unsigned    live_items = 0;
  int unsigned    src_idle_pct = 0;
  int unsigned    sink_stall_pct = 0;
  bit             hold_req = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard limit on run time
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame model
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] digit_at(input int unsigned pos);
    return 16'(frame_buf[pos % BufDepth]) - 16'(AsciiZero);
  endfunction

  // advance the model by one byte; returns 1 unless the byte is ignored
  function automatic bit parse_byte(input logic [7:0] b, output bit emits,
                                    output position_word_t word);
    bit live;
    live  = armed || b == StartMark || b == EndMark;
    emits = 1'b0;
    word  = '0;
    if (b == StartMark) begin
      wr_idx = 0;
      armed  = 1'b1;
    end else if (b == EndMark) begin
      if (armed) begin
        word.pos_x     = 8'(digit_at(PosXHi) * 16'd10 + digit_at(PosXLo));
        word.pos_y     = 8'(digit_at(PosYHi) * 16'd10 + digit_at(PosYLo));
        word.heading   = digit_at(PosHd2) * 16'd100 + digit_at(PosHd1) * 16'd10
                         + digit_at(PosHd0);
        word.wall_code = frame_buf[PosWall % BufDepth];
        word.changed   = word.pos_x != last_word.pos_x || word.pos_y != last_word.pos_y
                         || word.heading != last_word.heading
                         || word.wall_code != last_word.wall_code;
        last_word = word;
        emits     = 1'b1;
      end
      wr_idx = 0;
      armed  = 1'b0;
    end else if (armed) begin
      frame_buf[wr_idx] = b;
      wr_idx = (wr_idx >= BufDepth - 1) ? 0 : wr_idx + 1;
    end
    return live;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte source: called and returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input position_word_t typed_word);
    bit             emits;
    position_word_t word;
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    if (parse_byte(b, emits, word)) live_items++;
    if (emits) pending_words.push_back(typed ? typed_word : word);
    @(negedge clk_i);
  endtask

  task automatic send_burst();
    while (burst.size() != 0) send_byte(burst.pop_front(), 1'b0, '0);
  endtask

  // drop valid and wait for every outstanding word
  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random frame generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == StartMark || b == EndMark);
    return b;
  endfunction

  // mostly digits, sometimes anything but a mark
  function automatic logic [7:0] field_byte();
    return ($urandom_range(3) == 0) ? plain_byte() : 8'(AsciiZero + $urandom_range(9));
  endfunction

  task automatic queue_frame(input bit reuse, input bit corrupt);
    logic [7:0] body [11];
    if (reuse) begin
      body = prev_body;
    end else begin
      for (int i = 0; i < 11; i++) body[i] = 8'(AsciiZero + $urandom_range(9));
      body[2] = Comma;
      body[5] = Comma;
      body[9] = Comma;
      body[PosWall] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(15));
      if (corrupt) body[$urandom_range(10)] = 8'($urandom_range(255));
      prev_body = body;
    end
    burst.push_back(StartMark);
    foreach (body[i]) burst.push_back(body[i]);
    burst.push_back(EndMark);
  endtask

  task automatic queue_segment();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // well formed, sometimes a repeat of the previous body or a bad character
      queue_frame($urandom_range(3) == 0, $urandom_range(6) == 0);
    end else if (pick < 65) begin
      // short frame: unwritten positions keep old contents
      len = $urandom_range(10);
      burst.push_back(StartMark);
      repeat (len) burst.push_back(field_byte());
      burst.push_back(EndMark);
    end else if (pick < 73) begin
      // long frame: write index wraps
      len = $urandom_range(45, 21);
      burst.push_back(StartMark);
      repeat (len) burst.push_back(field_byte());
      burst.push_back(EndMark);
    end else if (pick < 83) begin
      // start mark while armed, then a full frame
      burst.push_back(StartMark);
      repeat ($urandom_range(8, 1)) burst.push_back(field_byte());
      queue_frame(1'b0, 1'b0);
    end else begin
      // noise between frames, stray marks included
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(3) == 0) burst.push_back($urandom_range(1) ? StartMark : EndMark);
        else burst.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_random(input int unsigned target);
    while (live_items < target) begin
      queue_segment();
      send_burst();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------
  function automatic string show(input position_word_t w);
    return $sformatf("x=%0d y=%0d hdg=%0d wall=%02h chg=%0b",
                     w.pos_x, w.pos_y, w.heading, w.wall_code, w.changed);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 10) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_word();
    position_word_t got;
    position_word_t want;
    got = {res_ch.pos_x, res_ch.pos_y, res_ch.heading, res_ch.wall_code, res_ch.changed};
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %s", show(got)));
    end else begin
      want = pending_words.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
          || got.heading !== want.heading || got.wall_code !== want.wall_code
          || got.changed !== want.changed) begin
        report_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_word();
  end

  // sink ready: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    string digits;
    rst_ni        = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    for (int i = 0; i < BufDepth; i++) frame_buf[i] = '0;
    for (int i = 0; i < 11; i++) prev_body[i] = AsciiZero;
    wr_idx    = 0;
    armed     = 1'b0;
    last_word = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    directed_rows.push_back({EndMark, 1'b0, 41'b0});     // end mark while idle
    directed_rows.push_back({8'hFF, 1'b0, 41'b0});       // ignored while idle
    directed_rows.push_back({StartMark, 1'b0, 41'b0});   // empty frame, buffer all zero
    directed_rows.push_back({EndMark, 1'b1, {8'd240, 8'd240, 16'd60208, 8'h00, 1'b1}});
    directed_rows.push_back({StartMark, 1'b0, 41'b0});   // same again: no change
    directed_rows.push_back({EndMark, 1'b1, {8'd240, 8'd240, 16'd60208, 8'h00, 1'b0}});
    directed_rows.push_back({StartMark, 1'b0, 41'b0});   // all nines, wall all ones
    digits = "99,99,999,";
    for (int i = 0; i < digits.len(); i++) directed_rows.push_back({digits[i], 1'b0, 41'b0});
    directed_rows.push_back({8'hFF, 1'b0, 41'b0});
    directed_rows.push_back({EndMark, 1'b1, {8'd99, 8'd99, 16'd999, 8'hFF, 1'b1}});
    directed_rows.push_back({StartMark, 1'b0, 41'b0});   // restart keeps the buffer
    directed_rows.push_back({AsciiZero, 1'b0, 41'b0});
    directed_rows.push_back({StartMark, 1'b0, 41'b0});
    directed_rows.push_back({EndMark, 1'b0, 41'b0});
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].word);
    end
    drain();

    // random: sender idles less than the sink stalls, then the reverse
    src_idle_pct   = 23;
    sink_stall_pct = 50;
    run_random(live_items + PhaseItems);
    drain();

    src_idle_pct   = 50;
    sink_stall_pct = 23;
    run_random(live_items + PhaseItems);
    drain();

    // no idling; starts with a long sink hold-off so the input backs up
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    run_random(live_items + PhaseItems);
    drain();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/fpp_pkg.sv
rtl/core/fpp_if.sv
rtl/core/framed_ascii_position_parser.sv
rtl/core/fpp_checker.sv
verif/testbench.sv
